/* rtl/vcsl_pkg.sv */
// Package for the velocity command slew limiter: field widths, register map,
// item kinds and the shaping, conversion and ramp functions.
// No dependencies.
`timescale 1ns / 1ps

package vcsl_pkg;

  localparam int VelW  = 16;   // velocity fields, signed
  localparam int StepW = 15;   // step and clamp registers
  localparam int TickW = 16;   // timeout counter
  localparam int InvW  = 2;
  localparam int AddrW = 5;    // 8 registers at 4-byte spacing
  localparam int DataW = 32;

  // rad/s * 180/pi * 256/4096 in Q16
  localparam logic [17:0] ANG_CONV_Q16 = 18'd234684;
  localparam logic [TickW-1:0] TIMEOUT_RESET = 16'd10;

  typedef enum logic [2:0] {
    REG_LIN_UP    = 3'd0,
    REG_LIN_DOWN  = 3'd1,
    REG_ANG_UP    = 3'd2,
    REG_ANG_DOWN  = 3'd3,
    REG_MAX_LIN   = 3'd4,
    REG_MAX_ANG   = 3'd5,
    REG_INVERT    = 3'd6,
    REG_TIMEOUT   = 3'd7
  } reg_idx_t;

  typedef enum logic {
    OP_CMD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Optional negate, then symmetric clamp (zero limit = no clamp).
  // 17 bits so that negated -32768 survives.
  function automatic logic signed [VelW:0] shape_cmd(
    input logic signed [VelW-1:0] v,
    input logic                   neg,
    input logic [StepW-1:0]       lim
  );
    logic signed [VelW:0] x;
    logic signed [VelW:0] limv;
    x    = {v[VelW-1], v};
    limv = {2'b00, lim};
    if (neg) begin
      x = -x;
    end
    if (lim != '0) begin
      if (x > limv) begin
        x = limv;
      end else if (x < -limv) begin
        x = -limv;
      end
    end
    return x;
  endfunction

  function automatic logic signed [VelW-1:0] sat_lin(input logic signed [VelW:0] x);
    logic signed [VelW-1:0] r;
    if (x > 17'sd32767) begin
      r = 16'sh7fff;
    end else begin
      r = x[VelW-1:0];
    end
    return r;
  endfunction

  // Angular rad/s (1/4096) to deg/s (1/256), round half away from zero, saturate.
  function automatic logic signed [VelW-1:0] conv_ang(input logic signed [VelW:0] z);
    logic [VelW:0]  mag;
    logic [34:0]    prod;
    logic [18:0]    rnd;
    logic [VelW:0]  capped;
    logic           neg;
    neg  = z[VelW];
    mag  = neg ? 17'(-z) : 17'(z);
    prod = 35'(mag) * 35'(ANG_CONV_Q16);
    rnd  = 19'((prod + 35'd32768) >> 16);
    if (neg) begin
      capped = (rnd > 19'd32768) ? 17'd32768 : rnd[VelW:0];
      return 16'(-capped);
    end else begin
      capped = (rnd > 19'd32767) ? 17'd32767 : rnd[VelW:0];
      return capped[VelW-1:0];
    end
  endfunction

  // One ramp step toward goal; zero step means jump.
  function automatic logic signed [VelW-1:0] ramp_step(
    input logic signed [VelW-1:0] cur,
    input logic signed [VelW-1:0] goal,
    input logic [StepW-1:0]       up,
    input logic [StepW-1:0]       down
  );
    logic [VelW:0] diff;
    logic signed [VelW-1:0] r;
    r = cur;
    if (cur < goal) begin
      diff = 17'({goal[VelW-1], goal} - {cur[VelW-1], cur});
      if (up == '0 || diff < {2'b00, up}) begin
        r = goal;
      end else begin
        r = cur + $signed({1'b0, up});
      end
    end else if (cur > goal) begin
      diff = 17'({cur[VelW-1], cur} - {goal[VelW-1], goal});
      if (down == '0 || diff < {2'b00, down}) begin
        r = goal;
      end else begin
        r = cur - $signed({1'b0, down});
      end
    end
    return r;
  endfunction

endpackage

/* rtl/velocity_command_slew_limiter_core.sv */
// Velocity command slew limiter, top level: input stage, shaping and ramp
// logic, result register and APB register file. Depends on vcsl_pkg.
`timescale 1ns / 1ps

// Usage
//   s_axis: one item per handshake. tuser says what the item is (op, link_up,
//   odom_reset_pending); tdata carries the linear and angular command.
//   A command item sets both targets and restarts the timeout; it gives no
//   result. A tick item counts the timeout, zeroes the targets on expiry and,
//   unless an odometry reset is pending, steps both velocities and sends one
//   result on m_axis. Items with link_up low change nothing.
//   APB: eight registers at byte addresses 0x00..0x1c. The user must write them
//   only while idle; the block itself does not enforce this.
// Throughput and datapath
//   One item per cycle while m_axis is not stalled. A tick's result passes through
//   the input register, then the result register, before it appears on m_axis.
//   The shape/convert/ramp step between the two registers is combinational,
//   with one 17x18 multiply.
// Reset
//   rst clears both stages, velocities, targets and the timeout, and loads
//   the register defaults (all zero, timeout_ticks = 10).
// Stall
//   While m_axis is stalled, the waiting result holds; commands keep flowing,
//   a following tick waits in the input register and s_axis_tready drops.

module velocity_command_slew_limiter_core
  import vcsl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // slave side
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,  // [15:0] cmd_linear, [31:16] cmd_angular
  input  logic [2:0]       s_axis_tuser,  // [0] op, [1] link_up, [2] odom_reset_pending
  // master side
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [15:0] drive_linear, [31:16] drive_angular
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // ---------------- configuration registers ----------------
  logic [StepW-1:0] linear_up_step, linear_down_step;
  logic [StepW-1:0] angular_up_step, angular_down_step;
  logic [StepW-1:0] max_linear, max_angular;
  logic [InvW-1:0]  invert_mode;
  logic [TickW-1:0] timeout_ticks;
  reg_idx_t         reg_idx;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[AddrW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_up_step    <= '0;
      linear_down_step  <= '0;
      angular_up_step   <= '0;
      angular_down_step <= '0;
      max_linear        <= '0;
      max_angular       <= '0;
      invert_mode       <= '0;
      timeout_ticks     <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_LIN_UP:   linear_up_step    <= pwdata[StepW-1:0];
        REG_LIN_DOWN: linear_down_step  <= pwdata[StepW-1:0];
        REG_ANG_UP:   angular_up_step   <= pwdata[StepW-1:0];
        REG_ANG_DOWN: angular_down_step <= pwdata[StepW-1:0];
        REG_MAX_LIN:  max_linear        <= pwdata[StepW-1:0];
        REG_MAX_ANG:  max_angular       <= pwdata[StepW-1:0];
        REG_INVERT:   invert_mode       <= pwdata[InvW-1:0];
        REG_TIMEOUT:  timeout_ticks     <= pwdata[TickW-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LIN_UP:   prdata = DataW'(linear_up_step);
      REG_LIN_DOWN: prdata = DataW'(linear_down_step);
      REG_ANG_UP:   prdata = DataW'(angular_up_step);
      REG_ANG_DOWN: prdata = DataW'(angular_down_step);
      REG_MAX_LIN:  prdata = DataW'(max_linear);
      REG_MAX_ANG:  prdata = DataW'(max_angular);
      REG_INVERT:   prdata = DataW'(invert_mode);
      REG_TIMEOUT:  prdata = DataW'(timeout_ticks);
      default:      prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic                   s1_valid;
  op_t                    s1_op;
  logic                   s1_link, s1_odom;
  logic signed [VelW-1:0] s1_lin, s1_ang;
  logic                   s1_emits, s1_fire, out_free;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_emits      = (s1_op == OP_TICK) && s1_link && !s1_odom;
  // commands, link-down items and odometry-pending ticks never need the result register
  assign s1_fire       = s1_valid && (!s1_emits || out_free);
  assign s_axis_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_op   <= op_t'(s_axis_tuser[0]);
      s1_link <= s_axis_tuser[1];
      s1_odom <= s_axis_tuser[2];
      s1_lin  <= s_axis_tdata[15:0];
      s1_ang  <= s_axis_tdata[31:16];
    end
  end

  // ---------------- item processing ----------------
  logic signed [VelW-1:0] linear_now, angular_now, linear_goal, angular_goal;
  logic [TickW-1:0]       idle_ticks;
  logic                   timeout_armed;

  logic signed [VelW-1:0] linear_now_next, angular_now_next;
  logic signed [VelW-1:0] linear_goal_next, angular_goal_next;
  logic [TickW-1:0]       idle_ticks_next;
  logic                   timeout_armed_next;
  logic signed [VelW:0]   shaped_lin, shaped_ang;

  assign shaped_lin = shape_cmd(s1_lin, invert_mode[0], max_linear);
  assign shaped_ang = shape_cmd(s1_ang, invert_mode[1], max_angular);

  always_comb begin
    linear_now_next    = linear_now;
    angular_now_next   = angular_now;
    linear_goal_next   = linear_goal;
    angular_goal_next  = angular_goal;
    idle_ticks_next    = idle_ticks;
    timeout_armed_next = timeout_armed;
    if (s1_link) begin
      unique case (s1_op)
        OP_CMD: begin
          linear_goal_next   = sat_lin(shaped_lin);
          angular_goal_next  = conv_ang(shaped_ang);
          idle_ticks_next    = '0;
          timeout_armed_next = 1'b1;
        end
        OP_TICK: begin
          // timeout runs even while an odometry reset is pending
          if (timeout_armed) begin
            if (idle_ticks != '1) begin
              idle_ticks_next = idle_ticks + 1'b1;
            end
            if (idle_ticks_next >= timeout_ticks) begin
              linear_goal_next   = '0;
              angular_goal_next  = '0;
              timeout_armed_next = 1'b0;
            end
          end
          if (!s1_odom) begin
            linear_now_next  = ramp_step(linear_now, linear_goal_next,
                                         linear_up_step, linear_down_step);
            angular_now_next = ramp_step(angular_now, angular_goal_next,
                                         angular_up_step, angular_down_step);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_now    <= '0;
      angular_now   <= '0;
      linear_goal   <= '0;
      angular_goal  <= '0;
      idle_ticks    <= '0;
      timeout_armed <= 1'b0;
    end else if (s1_fire) begin
      linear_now    <= linear_now_next;
      angular_now   <= angular_now_next;
      linear_goal   <= linear_goal_next;
      angular_goal  <= angular_goal_next;
      idle_ticks    <= idle_ticks_next;
      timeout_armed <= timeout_armed_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= s1_fire && s1_emits;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emits) begin
      m_axis_tdata <= {angular_now_next, linear_now_next};
    end
  end

  // ---------------- assertions ----------------
  a_tick_emits: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_emits |=> m_axis_tvalid && m_axis_tdata[15:0] == linear_now)
    else $error("ticked item did not produce its result");

  a_cmd_arms: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_link && s1_op == OP_CMD |=> timeout_armed && idle_ticks == '0)
    else $error("command did not restart the timeout");

  a_link_down: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !s1_link |=> $stable(linear_goal) && $stable(linear_now)
                            && $stable(angular_now) && $stable(timeout_armed))
    else $error("item with link down changed state");

  a_odom_hold: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_odom |=> $stable(linear_now) && $stable(angular_now))
    else $error("velocity moved while odometry reset pending");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_axis_tready)
    else $error("input stage empty but not ready");

endmodule
